// ===== src/sbbf_pkg.sv =====
// shared types and constants of the single hash bloom filter
`default_nettype none

package sbbf_pkg;

   localparam int HASH_W        = 32;
   localparam int KEY_W         = 8;
   localparam int TABLE_INDEX_W = 10;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 16;

   localparam logic [HASH_W-1:0] MIX_MULT   = 32'h5bd1e995;
   localparam int                MIX_SHIFT  = 15;
   localparam logic [HASH_W-1:0] SEED_RESET = 32'h12345678;

   localparam int MOD_BITS   = 4;
   localparam int MOD_STAGES = HASH_W / MOD_BITS;
   localparam int CMD_DEPTH  = 4;
   localparam int OUT_DEPTH  = 4;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_QUERY  = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   localparam int ACTION_W = $bits(action_type);

   typedef struct packed {
      logic q_pop;
      logic init_busy;
   } back_stat_type;

endpackage

`default_nettype wire

// ===== src/sbbf_queue.sv =====
// small register fifo between pipeline parts
`default_nettype none

module sbbf_queue #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           pop_data,
   output logic                            full,
   output logic                            empty,
   output logic      [$clog2(DEPTH):0]     count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;

   logic [WIDTH-1:0] store_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = store_ff[rd_ptr_ff];
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

`default_nettype wire

// ===== src/sbbf_front.sv =====
// front part: key byte hashing and pipelined reduction of the hash to a table index
`default_nettype none

module sbbf_front #(
   parameter int TABLE_SIZE = 701
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sbbf_pkg::ACTION_W-1:0]     action,
   input  wire logic [sbbf_pkg::KEY_W-1:0]        key_byte,
   input  wire logic                              key_last,
   input  wire logic [sbbf_pkg::HASH_W-1:0]       hash_seed,
   input  wire sbbf_pkg::back_stat_type           back_stat,
   input  wire logic                              advance,
   output logic                                   cmd_valid,
   output logic [sbbf_pkg::ACTION_W+$clog2(TABLE_SIZE)-1:0] cmd_data
);

   import sbbf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W:0] TS_C = (IDX_W + 1)'(TABLE_SIZE);

   logic              accept;
   logic              emit;
   logic [HASH_W-1:0] hash_start;
   logic [HASH_W-1:0] hash_xor;
   logic [HASH_W-1:0] hash_prod;
   logic [HASH_W-1:0] hash_mix;

   logic              in_prog_ff, in_prog_in;
   logic [HASH_W-1:0] run_ff, run_in;

   logic              st_valid_ff [0:MOD_STAGES];
   action_type        st_op_ff    [0:MOD_STAGES];
   logic [HASH_W-1:0] st_hash_ff  [0:MOD_STAGES];
   logic [IDX_W-1:0]  st_rem_ff   [0:MOD_STAGES];

   assign req_tready = advance && !back_stat.init_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hash_start = in_prog_ff ? run_ff : hash_seed;
      hash_xor   = hash_start ^ HASH_W'(key_byte);
      hash_prod  = hash_xor * MIX_MULT;
      hash_mix   = hash_prod ^ (hash_prod >> MIX_SHIFT);
   end

   always_comb begin
      in_prog_in = in_prog_ff;
      run_in     = run_ff;
      emit       = 1'b0;
      if (accept) begin
         case (action)
            ACT_INSERT, ACT_QUERY: begin
               if (key_last) begin
                  in_prog_in = 1'b0;
                  emit       = 1'b1;
               end else begin
                  in_prog_in = 1'b1;
                  run_in     = hash_mix;
               end
            end
            ACT_CLEAR: begin
               in_prog_in = 1'b0;
               emit       = 1'b1;
            end
            default: begin
               in_prog_in = in_prog_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_prog_ff     <= 1'b0;
         st_valid_ff[0] <= 1'b0;
      end else begin
         in_prog_ff <= in_prog_in;
         if (advance) begin
            st_valid_ff[0] <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (advance) begin
         st_op_ff[0]   <= action_type'(action);
         st_hash_ff[0] <= hash_mix;
         st_rem_ff[0]  <= '0;
      end
   end

   for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
      logic [IDX_W-1:0] rem_in;
      logic [IDX_W:0]   trial;

      // restoring remainder, msb first, MOD_BITS (four) hash bits per stage
      always_comb begin
         rem_in = st_rem_ff[s];
         trial  = '0;
         for (int j = 0; j < MOD_BITS; j++) begin
            trial = {rem_in, st_hash_ff[s][HASH_W - 1 - MOD_BITS * s - j]};
            if (trial >= TS_C) begin
               trial = trial - TS_C;
            end
            rem_in = trial[IDX_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            st_valid_ff[s+1] <= st_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            st_op_ff[s+1]   <= st_op_ff[s];
            st_hash_ff[s+1] <= st_hash_ff[s];
            st_rem_ff[s+1]  <= rem_in;
         end
      end
   end

   assign cmd_valid = st_valid_ff[MOD_STAGES];
   assign cmd_data  = {st_op_ff[MOD_STAGES], st_rem_ff[MOD_STAGES]};

endmodule

`default_nettype wire

// ===== src/sbbf_back.sv =====
// back part: bit table access, clear sweep and result buffering
`default_nettype none

module sbbf_back #(
   parameter int TABLE_SIZE = 701
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_empty,
   input  wire logic [sbbf_pkg::ACTION_W+$clog2(TABLE_SIZE)-1:0] q_data,
   output sbbf_pkg::back_stat_type                back_stat,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sbbf_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tuser
);

   import sbbf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int OCW   = $clog2(OUT_DEPTH) + 1;
   localparam int OUT_W = TABLE_INDEX_W + 2;

   typedef enum logic {
      ST_RUN,
      ST_CLEAR
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] sweep_ptr_ff;
   logic             init_ff;
   logic             b_valid_ff;
   logic             b_insert_ff;
   logic [IDX_W-1:0] b_idx_ff;
   logic             lw_valid_ff;
   logic [IDX_W-1:0] lw_idx_ff;
   logic             rdata_ff;

   logic             table_mem [0:TABLE_SIZE-1];

   action_type       head_op;
   logic [IDX_W-1:0] head_idx;
   logic             out_room;
   logic             q_pop;
   logic             was_set;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic             sweep_done;

   logic [OUT_W-1:0] out_push_data;
   logic [OUT_W-1:0] out_pop_data;
   logic             out_full;
   logic             out_empty;
   logic [OCW-1:0]   out_count;

   assign head_op  = action_type'(q_data[IDX_W +: ACTION_W]);
   assign head_idx = q_data[IDX_W-1:0];

   // a popped word passes the b_valid_ff stage before it reaches the output fifo, so that stage counts against the room
   assign out_room = ({1'b0, out_count} + (OCW + 1)'(b_valid_ff)) < (OCW + 1)'(OUT_DEPTH);
   assign q_pop    = (state_ff == ST_RUN) && !q_empty && out_room;

   assign sweep_done = (sweep_ptr_ff == IDX_W'(TABLE_SIZE - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ptr_ff <= '0;
         init_ff      <= 1'b1;
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         b_valid_ff <= q_pop && (head_op != ACT_CLEAR);
         if (b_valid_ff && b_insert_ff) begin
            lw_valid_ff <= 1'b1;
         end
         case (state_ff)
            ST_RUN: begin
               if (q_pop && (head_op == ACT_CLEAR)) begin
                  state_ff     <= ST_CLEAR;
                  sweep_ptr_ff <= '0;
               end
            end
            ST_CLEAR: begin
               sweep_ptr_ff <= sweep_ptr_ff + IDX_W'(1);
               if (sweep_done) begin
                  state_ff    <= ST_RUN;
                  init_ff     <= 1'b0;
                  lw_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      b_insert_ff <= (head_op == ACT_INSERT);
      b_idx_ff    <= head_idx;
      if (b_valid_ff && b_insert_ff) begin
         lw_idx_ff <= b_idx_ff;
      end
   end

   assign mem_we    = (state_ff == ST_CLEAR) || (b_valid_ff && b_insert_ff);
   assign mem_waddr = (state_ff == ST_CLEAR) ? sweep_ptr_ff : b_idx_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= table_mem[head_idx];
      if (mem_we) begin
         table_mem[mem_waddr] <= (state_ff != ST_CLEAR);
      end
   end

   // the insert one word ahead is not yet in the read data
   assign was_set = rdata_ff || (lw_valid_ff && (lw_idx_ff == b_idx_ff));

   assign out_push_data = {b_insert_ff, TABLE_INDEX_W'(b_idx_ff), was_set};

   sbbf_queue #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (b_valid_ff),
      .push_data (out_push_data),
      .pop       (rsp_tvalid && rsp_tready),
      .pop_data  (out_pop_data),
      .full      (out_full),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign rsp_tvalid = !out_empty;
   assign rsp_tdata  = RSP_TDATA_W'(out_pop_data[TABLE_INDEX_W:0]);
   assign rsp_tuser  = out_pop_data[TABLE_INDEX_W+1];

   assign back_stat.q_pop     = q_pop;
   assign back_stat.init_busy = init_ff;

   a_out_no_overflow: assert property (
      @(posedge clock) disable iff (reset) b_valid_ff |-> !out_full
   ) else $error("result fifo overflow");

   a_sweep_no_lookup: assert property (
      @(posedge clock) disable iff (reset) (state_ff == ST_CLEAR) |-> !b_valid_ff
   ) else $error("table lookup during clear sweep");

   a_sweep_end: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && sweep_done |=> (state_ff == ST_RUN) && !lw_valid_ff && !init_ff
   ) else $error("clear sweep did not finish cleanly");

endmodule

`default_nettype wire

// ===== src/single_hash_bloom_filter.sv =====
// Single hash bloom filter over byte streamed keys. One key byte is accepted per
// cycle while req_tready is high; the rate is set by the running hash update, one
// 32x32 multiply per byte in the front part. A key's last byte gives one result
// after the hash register, the eight stage remainder pipeline, the command queue
// and the registered table read. A clear word empties the table with a sweep over
// all TABLE_SIZE entries in the back part, during which the front keeps taking
// bytes until its queue fills. After reset the table is swept the same way, and
// req_tready stays low until it is done. The seed register may only be
// written while the block is idle.
`default_nettype none

module single_hash_bloom_filter #(
   parameter int TABLE_SIZE = 701
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [sbbf_pkg::REQ_TDATA_W-1:0]    req_tdata,   // key_byte
   input  wire logic [sbbf_pkg::ACTION_W-1:0]       req_tuser,   // action
   input  wire logic                                req_tlast,   // key_last
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [sbbf_pkg::RSP_TDATA_W-1:0]         rsp_tdata,   // bit_was_set, table_index
   output logic                                     rsp_tuser,   // was_insert
   input  wire logic                                csr_wr_en,
   input  wire logic [sbbf_pkg::HASH_W-1:0]         csr_wr_data  // hash_seed
);

   import sbbf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CMD_W = ACTION_W + IDX_W;

   logic [HASH_W-1:0] seed_ff;
   back_stat_type     back_stat;
   logic              advance;
   logic              cmd_valid;
   logic [CMD_W-1:0]  cmd_data;
   logic              q_push;
   logic              q_full;
   logic              q_empty;
   logic [CMD_W-1:0]  q_data;
   logic [$clog2(CMD_DEPTH):0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   assign advance = !q_full || back_stat.q_pop;
   assign q_push  = cmd_valid && advance;

   sbbf_front #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .key_byte   (req_tdata[KEY_W-1:0]),
      .key_last   (req_tlast),
      .hash_seed  (seed_ff),
      .back_stat  (back_stat),
      .advance    (advance),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data)
   );

   sbbf_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (cmd_data),
      .pop       (back_stat.q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty),
      .count     (q_count)
   );

   sbbf_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .back_stat  (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_queue_count: assert property (
      @(posedge clock) disable iff (reset)
      q_push && !back_stat.q_pop |=> q_count != '0
   ) else $error("command queue lost a word");

endmodule

`default_nettype wire
